[rtl/wspi_pkg.sv]
package wspi_pkg;

    // Speed fraction bits (Q.FRAC_BITS); gains are always Q8.8
    localparam int FRAC_BITS  = 8;
    localparam int GAIN_FRAC  = 8;
    localparam int PROD_SHIFT = FRAC_BITS + GAIN_FRAC;
    localparam int RAW_SHIFT  = 16 - FRAC_BITS;

    localparam int SPEED_W = 24;
    localparam int ERR_W   = 25;
    localparam int DERIV_W = 26;
    localparam int INTEG_W = 22;
    localparam int GAIN_W  = 16;
    localparam int TRIM_W  = 10;
    localparam int PULSE_W = 16;
    localparam int DRIVE_W = 15;
    localparam int CFG_W   = 24;
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 26;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 48;
    localparam int PID_W   = 32;

    // 0.7324 as unsigned Q0.16
    localparam logic [15:0] RPM_SCALE_Q16 = 16'd47999;

    localparam logic signed [SPEED_W-1:0] SPEED_ONE = SPEED_W'(1 << FRAC_BITS);
    localparam logic signed [ACC_W-1:0]   SPEED_MAX = ACC_W'(8388607);
    localparam logic signed [ACC_W-1:0]   SPEED_MIN = -ACC_W'(8388608);
    localparam logic signed [DERIV_W-1:0] INTEG_WIN = DERIV_W'(500 << FRAC_BITS);
    localparam logic signed [DERIV_W-1:0] INTEG_LIM = DERIV_W'(5000 << FRAC_BITS);
    localparam logic signed [PID_W:0]     DRIVE_LIM = (PID_W+1)'(10000);

    typedef enum logic [2:0] {
        REG_TARGET = 3'd0,
        REG_GAIN_P = 3'd1,
        REG_GAIN_I = 3'd2,
        REG_GAIN_D = 3'd3,
        REG_GAIN_FF = 3'd4,
        REG_TRIM   = 3'd5
    } cfg_idx_t;

    // Microcode fields
    typedef enum logic [2:0] {
        MS_NONE,
        MS_SCALE_PULSE,
        MS_P_ERR,
        MS_I_INTEG,
        MS_D_DERIV,
        MS_FF_TARGET
    } msel_t;

    typedef enum logic [1:0] {
        AOP_HOLD,
        AOP_LOAD,
        AOP_ADD,
        AOP_TRIM
    } aop_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_RAW,
        OP_AVG,
        OP_ERR,
        OP_INTEG,
        OP_PID,
        OP_DRIVE,
        OP_ZERO,
        OP_OUT
    } op_t;

    typedef enum logic [1:0] {
        J_NEXT,
        J_NEAR,
        J_ALWAYS
    } jmp_t;

    typedef logic [3:0] pc_t;

    localparam pc_t STEP_OUT  = 4'd12;
    localparam pc_t STEP_ZERO = 4'd13;

    typedef struct packed {
        msel_t msel;
        aop_t  aop;
        op_t   op;
        jmp_t  jmp;
        pc_t   jaddr;
    } ucw_t;

    // Control store. The product register is loaded in one step and
    // consumed by the accumulator in the next.
    function automatic ucw_t ucode(input pc_t pc);
        ucw_t w;
        unique case (pc)
            4'd0:  w = '{MS_SCALE_PULSE, AOP_HOLD, OP_NOP,   J_NEXT,   STEP_OUT};
            4'd1:  w = '{MS_NONE,        AOP_LOAD, OP_NOP,   J_NEXT,   STEP_OUT};
            4'd2:  w = '{MS_NONE,        AOP_HOLD, OP_RAW,   J_NEXT,   STEP_OUT};
            4'd3:  w = '{MS_NONE,        AOP_HOLD, OP_AVG,   J_NEXT,   STEP_OUT};
            4'd4:  w = '{MS_NONE,        AOP_HOLD, OP_ERR,   J_NEAR,   STEP_ZERO};
            4'd5:  w = '{MS_P_ERR,       AOP_HOLD, OP_INTEG, J_NEXT,   STEP_OUT};
            4'd6:  w = '{MS_I_INTEG,     AOP_LOAD, OP_NOP,   J_NEXT,   STEP_OUT};
            4'd7:  w = '{MS_D_DERIV,     AOP_ADD,  OP_NOP,   J_NEXT,   STEP_OUT};
            4'd8:  w = '{MS_FF_TARGET,   AOP_ADD,  OP_NOP,   J_NEXT,   STEP_OUT};
            4'd9:  w = '{MS_NONE,        AOP_LOAD, OP_PID,   J_NEXT,   STEP_OUT};
            4'd10: w = '{MS_NONE,        AOP_TRIM, OP_NOP,   J_NEXT,   STEP_OUT};
            4'd11: w = '{MS_NONE,        AOP_HOLD, OP_DRIVE, J_NEXT,   STEP_OUT};
            4'd12: w = '{MS_NONE,        AOP_HOLD, OP_OUT,   J_NEXT,   STEP_OUT};
            4'd13: w = '{MS_NONE,        AOP_HOLD, OP_ZERO,  J_ALWAYS, STEP_OUT};
            default: w = '{MS_NONE,      AOP_HOLD, OP_OUT,   J_NEXT,   STEP_OUT};
        endcase
        return w;
    endfunction

endpackage

[rtl/wheel_speed_pi_feedforward_loop.sv]
// Channel   | Dir | Handshake                   | Contents
// s_axis    | in  | s_axis_tvalid/s_axis_tready | enc_pulses
// m_axis    | out | m_axis_tvalid/m_axis_tready | drive, speed_now
// cfg       | in  | cfg_wr_en (no wait)         | cfg_index, cfg_data
//
// One item runs 13 microcode steps after acceptance (7 when |target| < 1.0),
// all through a single shared 17x26 multiplier with a registered product.
// The next item is taken as soon as the sequencer returns to idle, even if
// the previous result is still waiting in the output register.
// The output step stalls only while that register is still full and m_axis_tready is low.
// rst_n clears control, loop state and loads the register reset values.
module wheel_speed_pi_feedforward_loop
    import wspi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] enc_pulses
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [14:0] drive, [38:15] speed_now, [39] zero
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    function automatic logic signed [ACC_W-1:0] shr_trunc(
        input logic signed [ACC_W-1:0] v,
        input int unsigned s
    );
        logic signed [ACC_W-1:0] bias;
        bias = v[ACC_W-1] ? ((ACC_W'(1) <<< s) - ACC_W'(1)) : '0;
        return (v + bias) >>> s;
    endfunction

    // control and loop state
    logic                       busy_reg, busy_next;
    pc_t                        pc_reg, pc_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SPEED_W-1:0]  target_reg, target_next;
    logic [GAIN_W-1:0]          gain_p_reg, gain_p_next;
    logic [GAIN_W-1:0]          gain_i_reg, gain_i_next;
    logic [GAIN_W-1:0]          gain_d_reg, gain_d_next;
    logic [GAIN_W-1:0]          gain_ff_reg, gain_ff_next;
    logic [TRIM_W-1:0]          trim_reg, trim_next;
    logic signed [SPEED_W-1:0]  filt_reg, filt_next;
    logic signed [INTEG_W-1:0]  integ_reg, integ_next;
    logic signed [ERR_W-1:0]    prev_reg, prev_next;

    // datapath
    logic signed [PULSE_W-1:0]  pulse_reg, pulse_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [SPEED_W-1:0]  raw_reg, raw_next;
    logic signed [ERR_W-1:0]    err_reg, err_next;
    logic signed [DERIV_W-1:0]  deriv_reg, deriv_next;
    logic signed [PID_W-1:0]    pid_reg, pid_next;
    logic signed [DRIVE_W-1:0]  drive_reg, drive_next;
    logic signed [DRIVE_W-1:0]  drive_out_reg, drive_out_next;
    logic signed [SPEED_W-1:0]  speed_out_reg, speed_out_next;

    ucw_t                       cw;
    logic                       near_zero;
    logic                       stall;
    logic                       in_acc;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [ACC_W-1:0]    raw_full;
    logic signed [SPEED_W:0]    avg_sum;
    logic signed [DERIV_W-1:0]  err_ext;
    logic signed [DERIV_W-1:0]  err_abs;
    logic signed [DERIV_W-1:0]  isum;
    logic signed [ACC_W-1:0]    trim_q;
    logic signed [PID_W-1:0]    ff_val;
    logic signed [PID_W:0]      dsum;

    assign cw            = ucode(pc_reg);
    assign near_zero     = (target_reg > -SPEED_ONE) && (target_reg < SPEED_ONE);
    assign stall         = busy_reg && (cw.op == OP_OUT) && out_valid_reg && !m_axis_tready;
    assign s_axis_tready = !busy_reg;
    assign in_acc        = s_axis_tvalid && !busy_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, speed_out_reg, drive_out_reg};

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cw.msel)
            MS_SCALE_PULSE:
            begin
                mul_a = {1'b0, RPM_SCALE_Q16};
                mul_b = MUL_B_W'(pulse_reg);
            end
            MS_P_ERR:
            begin
                mul_a = {1'b0, gain_p_reg};
                mul_b = MUL_B_W'(err_reg);
            end
            MS_I_INTEG:
            begin
                mul_a = {1'b0, gain_i_reg};
                mul_b = MUL_B_W'(integ_reg);
            end
            MS_D_DERIV:
            begin
                mul_a = {1'b0, gain_d_reg};
                mul_b = deriv_reg;
            end
            MS_FF_TARGET:
            begin
                mul_a = {1'b0, gain_ff_reg};
                mul_b = MUL_B_W'(target_reg);
            end
            MS_NONE:
            begin
                mul_a = '0;
                mul_b = '0;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg;
        target_next    = target_reg;
        gain_p_next    = gain_p_reg;
        gain_i_next    = gain_i_reg;
        gain_d_next    = gain_d_reg;
        gain_ff_next   = gain_ff_reg;
        trim_next      = trim_reg;
        filt_next      = filt_reg;
        integ_next     = integ_reg;
        prev_next      = prev_reg;
        pulse_next     = pulse_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        raw_next       = raw_reg;
        err_next       = err_reg;
        deriv_next     = deriv_reg;
        pid_next       = pid_reg;
        drive_next     = drive_reg;
        drive_out_next = drive_out_reg;
        speed_out_next = speed_out_reg;

        raw_full = shr_trunc(acc_reg, RAW_SHIFT);
        avg_sum  = (SPEED_W+1)'(filt_reg) + (SPEED_W+1)'(raw_reg);
        err_ext  = DERIV_W'(err_reg);
        err_abs  = err_ext[DERIV_W-1] ? -err_ext : err_ext;
        isum     = DERIV_W'(integ_reg) + ((err_abs < INTEG_WIN) ? err_ext : '0);
        trim_q   = ACC_W'({trim_reg, {PROD_SHIFT{1'b0}}});
        ff_val   = PID_W'(shr_trunc(acc_reg, PROD_SHIFT));
        dsum     = (PID_W+1)'(ff_val) + (PID_W+1)'(pid_reg);

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_TARGET:  target_next  = cfg_data;
                REG_GAIN_P:  gain_p_next  = cfg_data[GAIN_W-1:0];
                REG_GAIN_I:  gain_i_next  = cfg_data[GAIN_W-1:0];
                REG_GAIN_D:  gain_d_next  = cfg_data[GAIN_W-1:0];
                REG_GAIN_FF: gain_ff_next = cfg_data[GAIN_W-1:0];
                REG_TRIM:    trim_next    = cfg_data[TRIM_W-1:0];
                default:     ;
            endcase
        end

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        if (in_acc)
        begin
            pulse_next = s_axis_tdata;
            busy_next  = 1'b1;
            pc_next    = '0;
        end
        else if (busy_reg && !stall)
        begin
            if (cw.msel != MS_NONE)
                prod_next = mul_a * mul_b;

            unique case (cw.aop)
                AOP_LOAD: acc_next = ACC_W'(prod_reg);
                AOP_ADD:  acc_next = acc_reg + ACC_W'(prod_reg);
                AOP_TRIM: acc_next = target_reg[SPEED_W-1] ? acc_reg - trim_q
                                                          : acc_reg + trim_q;
                AOP_HOLD: acc_next = acc_reg;
                default:  acc_next = acc_reg;
            endcase

            unique case (cw.op)
                OP_RAW:
                begin
                    if (raw_full > SPEED_MAX)
                        raw_next = SPEED_MAX[SPEED_W-1:0];
                    else if (raw_full < SPEED_MIN)
                        raw_next = SPEED_MIN[SPEED_W-1:0];
                    else
                        raw_next = raw_full[SPEED_W-1:0];
                end
                OP_AVG:
                begin
                    // halve, truncating toward zero
                    filt_next = SPEED_W'((avg_sum + (SPEED_W+1)'(avg_sum[SPEED_W])) >>> 1);
                end
                OP_ERR:
                begin
                    err_next   = ERR_W'(target_reg) - ERR_W'(filt_reg);
                    deriv_next = DERIV_W'(ERR_W'(target_reg) - ERR_W'(filt_reg))
                                 - DERIV_W'(prev_reg);
                end
                OP_INTEG:
                begin
                    if (isum > INTEG_LIM)
                        integ_next = INTEG_LIM[INTEG_W-1:0];
                    else if (isum < -INTEG_LIM)
                        integ_next = INTEG_W'(-INTEG_LIM);
                    else
                        integ_next = isum[INTEG_W-1:0];
                    prev_next = err_reg;
                end
                OP_PID:
                    pid_next = PID_W'(shr_trunc(acc_reg, PROD_SHIFT));
                OP_DRIVE:
                begin
                    if (dsum > DRIVE_LIM)
                        drive_next = DRIVE_LIM[DRIVE_W-1:0];
                    else if (dsum < -DRIVE_LIM)
                        drive_next = DRIVE_W'(-DRIVE_LIM);
                    else
                        drive_next = dsum[DRIVE_W-1:0];
                end
                OP_ZERO:
                begin
                    drive_next = '0;
                    integ_next = '0;
                    prev_next  = '0;
                end
                OP_OUT:
                begin
                    drive_out_next = drive_reg;
                    speed_out_next = filt_reg;
                    out_valid_next = 1'b1;
                end
                OP_NOP:  ;
                default: ;
            endcase

            if (cw.op == OP_OUT)
            begin
                busy_next = 1'b0;
                pc_next   = '0;
            end
            else
            begin
                unique case (cw.jmp)
                    J_NEAR:   pc_next = near_zero ? cw.jaddr : pc_reg + 4'd1;
                    J_ALWAYS: pc_next = cw.jaddr;
                    J_NEXT:   pc_next = pc_reg + 4'd1;
                    default:  pc_next = pc_reg + 4'd1;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
            target_reg    <= '0;
            gain_p_reg    <= 16'd819;
            gain_i_reg    <= 16'd51;
            gain_d_reg    <= 16'd13;
            gain_ff_reg   <= 16'd3072;
            trim_reg      <= '0;
            filt_reg      <= '0;
            integ_reg     <= '0;
            prev_reg      <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            target_reg    <= target_next;
            gain_p_reg    <= gain_p_next;
            gain_i_reg    <= gain_i_next;
            gain_d_reg    <= gain_d_next;
            gain_ff_reg   <= gain_ff_next;
            trim_reg      <= trim_next;
            filt_reg      <= filt_next;
            integ_reg     <= integ_next;
            prev_reg      <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pulse_reg     <= pulse_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        raw_reg       <= raw_next;
        err_reg       <= err_next;
        deriv_reg     <= deriv_next;
        pid_reg       <= pid_next;
        drive_reg     <= drive_next;
        drive_out_reg <= drive_out_next;
        speed_out_reg <= speed_out_next;
    end

`ifndef NO_ASSERTIONS
    a_idle_pc: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> pc_reg == '0)
        else $error("sequencer idle with nonzero step counter");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> busy_reg && pc_reg == '0)
        else $error("accepted transaction did not start the sequencer");

    a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
        (DERIV_W'(integ_reg) <= INTEG_LIM) && (DERIV_W'(integ_reg) >= -INTEG_LIM))
        else $error("integral outside its clamp");

    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (drive_out_reg <= 15'sd10000) && (drive_out_reg >= -15'sd10000))
        else $error("drive outside saturation limits");

    a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !stall && cw.op == OP_ZERO |=> integ_reg == '0 && prev_reg == '0)
        else $error("near-zero target did not clear loop state");
`endif

endmodule

[tb/sv/wheel_speed_pi_feedforward_loop_tb.sv]
module wheel_speed_pi_feedforward_loop_tb
    import wspi_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_SETTINGS = 11;
    localparam int ITEMS_PER_SETTING = 75;
    localparam int LONG_STALL = 300;
    localparam int DRAIN_CYCLES = 20;

    // unmapped register indexes, writes must be dropped
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam longint INTEG_WINDOW_RPM = 500;
    localparam longint INTEG_CLAMP_RPM = 5000;
    localparam longint DRIVE_SAT = 10000;
    localparam longint SPEED_TOP = 8388607;
    localparam longint SPEED_BOTTOM = -8388608;

    typedef struct {
        logic signed [DRIVE_W-1:0] drive;
        logic signed [SPEED_W-1:0] speed;
    } wheel_result_t;

    class speed_loop_scoreboard;
        logic signed [SPEED_W-1:0] target;
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
        logic [GAIN_W-1:0] kff;
        logic [TRIM_W-1:0] trim;
        logic signed [SPEED_W-1:0] speed;
        logic signed [INTEG_W-1:0] integ;
        logic signed [ERR_W-1:0] last_err;
        wheel_result_t expected_q[$];
        int mismatches;
        int strays;
        int checked;
        int near_zero;

        function new();
            target = '0;
            kp = 16'd819;
            ki = 16'd51;
            kd = 16'd13;
            kff = 16'd3072;
            trim = '0;
            speed = '0;
            integ = '0;
            last_err = '0;
            mismatches = 0;
            strays = 0;
            checked = 0;
            near_zero = 0;
        endfunction

        function void load_reg(logic [2:0] idx, logic [CFG_W-1:0] d);
            case (idx)
                REG_TARGET:  target = d;
                REG_GAIN_P:  kp = d[GAIN_W-1:0];
                REG_GAIN_I:  ki = d[GAIN_W-1:0];
                REG_GAIN_D:  kd = d[GAIN_W-1:0];
                REG_GAIN_FF: kff = d[GAIN_W-1:0];
                REG_TRIM:    trim = d[TRIM_W-1:0];
                default: ;
            endcase
        endfunction

        function longint toward_zero(longint v, int sh);
            if (v < 0)
                return -((-v) >> sh);
            return v >> sh;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            if (v > hi)
                return hi;
            if (v < lo)
                return lo;
            return v;
        endfunction

        // one loop tick: filter update, then PID+feedforward, or zero drive
        function void note_pulse(logic [PULSE_W-1:0] pulse_bits);
            longint one;
            longint tgt;
            longint raw;
            longint err;
            longint deriv;
            longint acc;
            longint trim_q;
            longint ff;
            longint pid;
            longint drv;
            one = longint'(1) << FRAC_BITS;
            tgt = longint'(target);
            raw = toward_zero(longint'($signed(pulse_bits)) * longint'(RPM_SCALE_Q16), RAW_SHIFT);
            raw = clip(raw, SPEED_BOTTOM, SPEED_TOP);
            speed = SPEED_W'(toward_zero(longint'(speed) + raw, 1));
            err = tgt - longint'(speed);
            deriv = err - longint'(last_err);
            if ((tgt < 0 ? -tgt : tgt) < one) begin
                integ = '0;
                last_err = '0;
                drv = 0;
                near_zero++;
            end
            else begin
                acc = longint'(integ);
                if ((err < 0 ? -err : err) < INTEG_WINDOW_RPM * one)
                    acc += err;
                integ = INTEG_W'(clip(acc, -INTEG_CLAMP_RPM * one, INTEG_CLAMP_RPM * one));
                last_err = ERR_W'(err);
                trim_q = longint'(trim) << PROD_SHIFT;
                if (tgt < 0)
                    trim_q = -trim_q;
                ff = toward_zero(longint'(kff) * tgt + trim_q, PROD_SHIFT);
                pid = toward_zero(longint'(kp) * err + longint'(ki) * longint'(integ)
                                  + longint'(kd) * deriv, PROD_SHIFT);
                drv = clip(ff + pid, -DRIVE_SAT, DRIVE_SAT);
            end
            expected_q.push_back('{DRIVE_W'(drv), speed});
        endfunction

        function void check_result(logic [39:0] d);
            wheel_result_t e;
            if (expected_q.size() == 0) begin
                strays++;
                if (strays + mismatches <= 10)
                    $display("%t: result with nothing pending: drive %0d speed %0d", $realtime,
                             $signed(d[14:0]), $signed(d[38:15]));
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (d[14:0] !== e.drive || d[38:15] !== e.speed || d[39] !== 1'b0) begin
                mismatches++;
                if (strays + mismatches <= 10)
                    $display("%t: result %0d: drive exp %0d got %0d, speed exp %0d got %0d, pad %b",
                             $realtime, checked, e.drive, $signed(d[14:0]), e.speed,
                             $signed(d[38:15]), d[39]);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [15:0] s_axis_tdata;    // [15:0] enc_pulses
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [39:0] m_axis_tdata;    // [14:0] drive, [38:15] speed_now, [39] zero
    logic cfg_wr_en;
    logic [2:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    speed_loop_scoreboard sb = new();
    bit tx_gaps = 1'b0;
    bit rx_gaps = 1'b0;
    int rx_hold_len = 0;
    int cycle_count = 0;
    int pulses_sent = 0;
    int settings_run = 0;

    wheel_speed_pi_feedforward_loop u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[wheel_speed_pi_feedforward_loop] ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_pulse(s_axis_tdata);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // result side: random back-pressure bursts, plus one long hold on request
    initial
    begin
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rx_hold_len > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_len) @(posedge clk);
                rx_hold_len = 0;
                m_axis_tready <= 1'b1;
            end
            else if (rx_gaps && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic send_pulse(input logic [PULSE_W-1:0] p);
        if (tx_gaps && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= p;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pulses_sent++;
    endtask

    // block goes idle once every pending result has been taken
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [CFG_W-1:0] d);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        sb.load_reg(idx, d);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3: return GAIN_W'($urandom_range(0, 1023));
            default: return GAIN_W'($urandom());
        endcase
    endfunction

    task automatic run_setting(input int n_items, input bit with_gaps, input int hold);
        logic signed [SPEED_W-1:0] tgt;
        longint centre;
        int p;
        int r;
        case ($urandom_range(0, 9))
            0: tgt = SPEED_W'(int'($urandom_range(0, 510)) - 255);
            1: tgt = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            2: tgt = SPEED_W'($urandom());
            default: tgt = SPEED_W'($urandom_range(0, 1) ? int'($urandom_range(256, 1500000))
                                                          : -int'($urandom_range(256, 1500000)));
        endcase
        cfg_write(REG_TARGET, tgt);
        cfg_write(REG_GAIN_P, CFG_W'(pick_gain()));
        cfg_write(REG_GAIN_I, CFG_W'(pick_gain()));
        cfg_write(REG_GAIN_D, CFG_W'(pick_gain()));
        cfg_write(REG_GAIN_FF, CFG_W'(pick_gain()));
        cfg_write(REG_TRIM, CFG_W'($urandom_range(0, 1023)));
        if ($urandom_range(0, 3) == 0)
            cfg_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_W'($urandom()));
        settings_run++;

        // pulse count that would settle the filter onto the target
        centre = (longint'(tgt) * (longint'(1) << RAW_SHIFT)) / longint'(RPM_SCALE_Q16);
        if (centre > 32667)
            centre = 32667;
        if (centre < -32668)
            centre = -32668;

        tx_gaps = with_gaps && $urandom_range(0, 3) != 0;
        rx_gaps = with_gaps && $urandom_range(0, 3) != 0;
        rx_hold_len = hold;
        for (int i = 0; i < n_items; i++)
        begin
            r = $urandom_range(0, 19);
            if (r < 15)
                p = int'(centre) + int'($urandom_range(0, 200)) - 100;
            else if (r < 18)
                p = int'($signed(PULSE_W'($urandom())));
            else
                case ($urandom_range(0, 3))
                    0: p = 32767;
                    1: p = -32768;
                    2: p = 0;
                    default: p = -1;
                endcase
            send_pulse(PULSE_W'(p));
        end
        wait_for_drain();
    endtask

    initial
    begin
        longint cancel;
        int fails;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_TARGET;
        cfg_data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, target zero: drive stays at zero
        settings_run++;
        send_pulse(16'h7FFF);
        send_pulse(16'h8000);
        send_pulse(16'h0000);
        wait_for_drain();

        cfg_write(REG_SPARE_LO, CFG_W'($urandom()));
        cfg_write(REG_SPARE_HI, CFG_W'($urandom()));
        // target exactly one rpm, trim at the top of its range
        cfg_write(REG_TARGET, 24'd256);
        cfg_write(REG_TRIM, 24'd1023);
        settings_run++;
        send_pulse(16'h0001);
        send_pulse(16'hFFFF);
        send_pulse(16'h0000);
        wait_for_drain();

        cfg_write(REG_TARGET, 24'd255);
        settings_run++;
        send_pulse(16'h0000);
        wait_for_drain();

        cfg_write(REG_TARGET, 24'hFFFF00);
        settings_run++;
        send_pulse(16'h0000);
        send_pulse(16'h0005);
        wait_for_drain();

        // target and gains at the top: drive saturates
        cfg_write(REG_TARGET, 24'h7FFFFF);
        cfg_write(REG_GAIN_P, 24'hFFFF);
        cfg_write(REG_GAIN_I, 24'hFFFF);
        cfg_write(REG_GAIN_D, 24'hFFFF);
        cfg_write(REG_GAIN_FF, 24'hFFFF);
        cfg_write(REG_TRIM, 24'd1000);
        settings_run++;
        send_pulse(16'h7FFF);
        send_pulse(16'h8000);
        wait_for_drain();

        cfg_write(REG_TARGET, 24'h800000);
        cfg_write(REG_GAIN_P, '0);
        cfg_write(REG_GAIN_I, '0);
        cfg_write(REG_GAIN_D, '0);
        cfg_write(REG_GAIN_FF, '0);
        settings_run++;
        send_pulse(16'h0000);
        send_pulse(16'h8000);
        wait_for_drain();

        // error just inside the window, held: integral runs into its clamp
        cfg_write(REG_TARGET, 24'd127000);
        cfg_write(REG_GAIN_P, 24'd819);
        cfg_write(REG_GAIN_I, 24'd51);
        cfg_write(REG_GAIN_D, 24'd13);
        cfg_write(REG_GAIN_FF, 24'd3072);
        cfg_write(REG_TRIM, '0);
        settings_run++;
        cancel = -(longint'(sb.speed) * (longint'(1) << RAW_SHIFT)) / longint'(RPM_SCALE_Q16);
        if (cancel > 32767)
            cancel = 32767;
        if (cancel < -32768)
            cancel = -32768;
        send_pulse(PULSE_W'(cancel));
        repeat (11) send_pulse(16'h0000);
        wait_for_drain();

        for (int s = 0; s < RANDOM_SETTINGS; s++)
            run_setting(ITEMS_PER_SETTING, s < RANDOM_SETTINGS - 2, s == 3 ? LONG_STALL : 0);

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d pulse transactions across %0d register settings; %0d results checked,",
                 pulses_sent, settings_run, sb.checked);
        $display("%0d of them with the target below one rpm.", sb.near_zero);
        fails = sb.mismatches + sb.strays + sb.pending();
        if (fails == 0)
            $display("[wheel_speed_pi_feedforward_loop] OK");
        else
            $display("[wheel_speed_pi_feedforward_loop] ERROR");
        $finish;
    end

endmodule

[wheel_speed_pi_feedforward_loop.f]
rtl/wspi_pkg.sv
rtl/wheel_speed_pi_feedforward_loop.sv
tb/sv/wheel_speed_pi_feedforward_loop_tb.sv
